FILE: rtl/hsf_pkg.sv
// Shared constants and types for the scaled HMM forward block.
package hsf_pkg;

  localparam int unsigned PFB   = 15;           // fraction bits of a probability
  localparam int unsigned PW    = 16;           // probability field width
  localparam int unsigned PRODW = 2 * PW;       // product of two probabilities
  localparam int unsigned ACCW  = PRODW + 2;    // sum of up to four products
  localparam logic [PW-1:0] ONE = PW'(1) << PFB;

  localparam int unsigned LOGW  = 24;
  localparam int unsigned SUMW  = 48;
  localparam int unsigned LOGFB = 16;           // fraction bits of a log
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic signed [LOGW-1:0] LOG_MIN = {1'b1, {(LOGW-1){1'b0}}};
  localparam logic signed [SUMW-1:0] SUM_MIN = {1'b1, {(SUMW-1){1'b0}}};
  localparam logic signed [SUMW-1:0] SUM_MAX = {1'b0, {(SUMW-1){1'b1}}};

  localparam logic [1:0] OP_LOAD_TRANS = 2'd0;
  localparam logic [1:0] OP_LOAD_EQ    = 2'd1;
  localparam logic [1:0] OP_SITE       = 2'd2;

  typedef struct packed {
    logic          ld_en;
    logic [1:0]    ld_row;
    logic [PW-1:0] ld_val;
    logic          acc_clr;
    logic          mac_en;
    logic          emit_en;
    logic          div_start;
    logic          div_step;
  } lane_ctl_t;

  function automatic logic [PW-1:0] clamp_one(input logic [PW-1:0] v);
    clamp_one = (v > ONE) ? ONE : v;
  endfunction

endpackage

FILE: rtl/hsf_lane.sv
// One state lane: transition column, predict MAC, emission product, divider.
module hsf_lane #(
  parameter int unsigned STATES = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hsf_pkg::lane_ctl_t                ctl_i,
  input  logic [$clog2(STATES)-1:0]         k_i,
  input  logic [hsf_pkg::PW-1:0]            v_i,
  input  logic [hsf_pkg::PW-1:0]            emit_i,
  input  logic [hsf_pkg::PW-1:0]            scale_i,
  output logic [hsf_pkg::PW-1:0]            tmp_o,
  output logic [hsf_pkg::PW-1:0]            lik_o
);
  localparam int unsigned KW = $clog2(STATES);

  logic [hsf_pkg::PW-1:0]   col_q [STATES];
  logic [hsf_pkg::ACCW-1:0] acc_q, acc_d;
  logic [hsf_pkg::PW-1:0]   tmp_q, rem_q, quo_q, pred;
  logic                     sat_q;
  logic [hsf_pkg::PRODW-1:0] prod, eprod;
  logic [hsf_pkg::PW:0]     rem2;
  logic [hsf_pkg::ACCW-hsf_pkg::PFB-1:0] acc_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STATES; i++) col_q[i] <= '0;
    end else if (ctl_i.ld_en) begin
      col_q[ctl_i.ld_row[KW-1:0]] <= ctl_i.ld_val;
    end
  end

  assign prod   = col_q[k_i] * v_i;
  assign acc_d  = acc_q + hsf_pkg::ACCW'(prod);
  assign acc_sh = acc_q[hsf_pkg::ACCW-1:hsf_pkg::PFB];
  assign pred   = (acc_sh > (hsf_pkg::ACCW-hsf_pkg::PFB)'(hsf_pkg::ONE)) ?
                  hsf_pkg::ONE : acc_sh[hsf_pkg::PW-1:0];
  assign eprod  = emit_i * pred;
  assign rem2   = {rem_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc_clr) acc_q <= '0;
    else if (ctl_i.mac_en) acc_q <= acc_d;
    if (ctl_i.emit_en) tmp_q <= eprod[hsf_pkg::PFB +: hsf_pkg::PW];
    if (ctl_i.div_start) begin
      sat_q <= (tmp_q >= scale_i);
      rem_q <= tmp_q;
      quo_q <= '0;
    end else if (ctl_i.div_step) begin
      // restoring step: shift in one quotient bit
      if (rem2 >= {1'b0, scale_i}) begin
        rem_q <= hsf_pkg::PW'(rem2 - {1'b0, scale_i});
        quo_q <= {quo_q[hsf_pkg::PW-2:0], 1'b1};
      end else begin
        rem_q <= rem2[hsf_pkg::PW-1:0];
        quo_q <= {quo_q[hsf_pkg::PW-2:0], 1'b0};
      end
    end
  end

  assign tmp_o = tmp_q;
  assign lik_o = sat_q ? hsf_pkg::ONE : quo_q;
endmodule

FILE: rtl/hsf_log.sv
// Iterative natural log of the site scale, Q.16, by repeated squaring.
module hsf_log (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [hsf_pkg::PW-1:0]           scale_i,
  output logic                             busy_o,
  output logic signed [hsf_pkg::LOGW-1:0]  log_o
);
  logic        busy_q, mul_q;
  logic [3:0]  cnt_q;
  logic [31:0] m_q;
  logic [hsf_pkg::LOGFB-1:0] frac_q;
  logic [3:0]  p_q, p;
  logic [63:0] sq;
  logic [32:0] t;
  logic [19:0] neg_l2;
  logic [51:0] mag;
  logic signed [hsf_pkg::LOGW-1:0] log_q;

  always_comb begin
    p = '0;
    for (int i = 0; i < hsf_pkg::PW; i++) if (scale_i[i]) p = 4'(i);
  end

  assign sq     = m_q * m_q;
  assign t      = sq[63:31];
  assign neg_l2 = {4'(4'(hsf_pkg::PFB) - p_q), 16'd0} - {4'd0, frac_q};
  assign mag    = neg_l2 * hsf_pkg::LN2_Q32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mul_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      mul_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q && !mul_q) begin
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == 4'd15) mul_q <= 1'b1;
    end else if (mul_q) begin
      mul_q  <= 1'b0;
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q    <= p;
      m_q    <= 32'({16'd0, scale_i} << (5'd31 - {1'b0, p}));
      frac_q <= '0;
    end else if (busy_q && !mul_q) begin
      // square, renormalize to [1,2) and shift the overflow into the fraction
      if (t[32]) begin
        m_q    <= t[32:1];
        frac_q <= {frac_q[hsf_pkg::LOGFB-2:0], 1'b1};
      end else begin
        m_q    <= t[31:0];
        frac_q <= {frac_q[hsf_pkg::LOGFB-2:0], 1'b0};
      end
    end else if (mul_q) begin
      log_q <= -$signed({4'd0, mag[51:32]});
    end
  end

  assign busy_o = busy_q;
  assign log_o  = log_q;
endmodule

FILE: rtl/hmm_scaled_forward_top.sv
// Top level of the scaled HMM forward block: control, merge and output register.
//
//  Channel  Dir  Signals                   Contents
//  s_axis   in   tvalid/tready/tdata/tuser load or site request, tuser = opcode
//  m_axis   out  tvalid/tready/tdata/tuser one result per site, tuser = zero_scale
//
// A load is taken in idle and keeps the block there. A site runs from request to
// the next request through a MAC over the STATES vector entries, emission
// product, scale sum, a start state, then the divide state while the log unit runs
// 16 squarings and one multiply (the 15-step lane dividers finish inside it), the
// output state and idle.
// Reset clears tables, previous vector, running sum and all control.
// A stalled result holds in the output register; the next request is taken
// once the block is back in idle.
module hmm_scaled_forward_top #(
  parameter int unsigned STATES = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // from_state[1:0], to_state[3:2], load_value[19:4], emit_0[35:20],
  // emit_1[51:36], emit_2[67:52], emit_3[83:68], start_sequence[84],
  // restart_chain[85], zero fill [87:86]
  input  logic [87:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // lik_0[15:0], lik_1[31:16], lik_2[47:32], lik_3[63:48], site_scale[79:64],
  // log_scale[103:80], running_log_lik[151:104]
  output logic [151:0] m_axis_tdata,
  // zero_scale[0]
  output logic         m_axis_tuser
);
  localparam int unsigned KW = $clog2(STATES);
  localparam int unsigned CW = 4;
  localparam int unsigned PW = hsf_pkg::PW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_EMIT  = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_START = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]    state_q;
  logic [CW-1:0] cnt_q;
  logic          use_eq_q, start_q;
  logic [PW-1:0] eq_q [STATES];
  logic [PW-1:0] prev_q [STATES];
  logic [PW-1:0] emit_q [STATES];
  logic [PW-1:0] tmp [STATES];
  logic [PW-1:0] lik [STATES];
  logic [PW-1:0] scale_q;
  logic signed [hsf_pkg::SUMW-1:0] sum_q;
  logic          out_valid_q;
  logic [151:0]  out_data_q, out_data_d;
  logic          out_zero_q;

  logic [1:0]    from_st, to_st;
  logic [PW-1:0] ld_val;
  logic [PW-1:0] emit_in [4];
  logic          accept, in_range, log_busy, zero, out_fire;
  logic [KW-1:0] k;
  logic [PW-1:0] v_k;
  logic [PW+2:0] tsum;
  logic signed [hsf_pkg::LOGW-1:0] log_res, lg;
  logic signed [hsf_pkg::SUMW:0]   nsum;
  logic signed [hsf_pkg::SUMW-1:0] base, sum_d;
  hsf_pkg::lane_ctl_t ctl [STATES];

  assign from_st    = s_axis_tdata[1:0];
  assign to_st      = s_axis_tdata[3:2];
  assign ld_val     = hsf_pkg::clamp_one(s_axis_tdata[19:4]);
  assign emit_in[0] = s_axis_tdata[35:20];
  assign emit_in[1] = s_axis_tdata[51:36];
  assign emit_in[2] = s_axis_tdata[67:52];
  assign emit_in[3] = s_axis_tdata[83:68];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_range      = ({1'b0, from_st} < 3'(STATES));
  assign k             = cnt_q[KW-1:0];
  assign v_k           = use_eq_q ? eq_q[k] : prev_q[k];
  assign zero          = (scale_q == '0);
  assign out_fire      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    tsum = '0;
    for (int j = 0; j < STATES; j++) tsum = tsum + (PW+3)'(tmp[j]);
  end

  for (genvar j = 0; j < STATES; j++) begin : g_lane
    always_comb begin
      ctl[j].ld_en     = accept && (s_axis_tuser == hsf_pkg::OP_LOAD_TRANS) && in_range &&
                         ({1'b0, to_st} == 3'(j));
      ctl[j].ld_row    = from_st;
      ctl[j].ld_val    = ld_val;
      ctl[j].acc_clr   = accept && (s_axis_tuser == hsf_pkg::OP_SITE);
      ctl[j].mac_en    = (state_q == ST_MAC);
      ctl[j].emit_en   = (state_q == ST_EMIT);
      ctl[j].div_start = (state_q == ST_START);
      ctl[j].div_step  = (state_q == ST_DIV) && (cnt_q != CW'(hsf_pkg::PFB));
    end

    hsf_lane #(.STATES(STATES)) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[j]),
      .k_i     (k),
      .v_i     (v_k),
      .emit_i  (emit_q[j]),
      .scale_i (scale_q),
      .tmp_o   (tmp[j]),
      .lik_o   (lik[j])
    );
  end

  hsf_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_START),
    .scale_i (scale_q),
    .busy_o  (log_busy),
    .log_o   (log_res)
  );

  // merge: log, running sum with saturation
  assign lg    = zero ? hsf_pkg::LOG_MIN : log_res;
  assign base  = start_q ? '0 : sum_q;
  assign nsum  = (hsf_pkg::SUMW+1)'(base) + (hsf_pkg::SUMW+1)'(lg);
  assign sum_d = (nsum < (hsf_pkg::SUMW+1)'(hsf_pkg::SUM_MIN)) ? hsf_pkg::SUM_MIN :
                 (nsum > (hsf_pkg::SUMW+1)'(hsf_pkg::SUM_MAX)) ? hsf_pkg::SUM_MAX :
                 nsum[hsf_pkg::SUMW-1:0];

  always_comb begin
    out_data_d = '0;
    for (int i = 0; i < STATES; i++) out_data_d[i*PW +: PW] = zero ? '0 : lik[i];
    out_data_d[79:64]   = scale_q;
    out_data_d[103:80]  = lg;
    out_data_d[151:104] = sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      for (int i = 0; i < STATES; i++) begin
        eq_q[i]   <= '0;
        prev_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_fire || (out_valid_q && !m_axis_tready);
      case (state_q)
        ST_IDLE: begin
          if (accept && s_axis_tuser == hsf_pkg::OP_LOAD_EQ && in_range)
            eq_q[from_st[KW-1:0]] <= ld_val;
          if (accept && s_axis_tuser == hsf_pkg::OP_SITE) begin
            state_q <= ST_MAC;
            cnt_q   <= '0;
          end
        end
        ST_MAC: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(STATES - 1)) state_q <= ST_EMIT;
        end
        ST_EMIT:  state_q <= ST_SUM;
        ST_SUM:   state_q <= ST_START;
        ST_START: begin
          state_q <= ST_DIV;
          cnt_q   <= '0;
        end
        ST_DIV: begin
          if (cnt_q != CW'(hsf_pkg::PFB)) cnt_q <= cnt_q + CW'(1);
          else if (!log_busy) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_fire) begin
            sum_q       <= sum_d;
            for (int i = 0; i < STATES; i++) prev_q[i] <= zero ? '0 : lik[i];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tuser == hsf_pkg::OP_SITE) begin
      use_eq_q <= s_axis_tdata[84] | s_axis_tdata[85];
      start_q  <= s_axis_tdata[84];
      for (int i = 0; i < STATES; i++) emit_q[i] <= hsf_pkg::clamp_one(emit_in[i]);
    end
    if (state_q == ST_SUM)
      scale_q <= (tsum > (PW+3)'(hsf_pkg::ONE)) ? hsf_pkg::ONE : tsum[PW-1:0];
    if (out_fire) begin
      out_data_q <= out_data_d;
      out_zero_q <= zero;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_zero_q;
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the scaled HMM forward block.
module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [15:0]        lik [4];
    logic [15:0]        scale;
    logic signed [23:0] lg;
    logic signed [47:0] sum;
    logic               zero;
  } site_out_t;

  int errors = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Forward recursion predictor; holds its own copy of the tables and state.
  class forward_scoreboard;
    logic [15:0]        trans [4][4];
    logic [15:0]        eqf [4];
    logic [15:0]        prev [4];
    logic signed [47:0] run_sum;
    site_out_t          pending [$];
    int                 sites_seen, zero_seen, checked;

    function new();
      foreach (trans[i, j]) trans[i][j] = '0;
      foreach (eqf[i]) begin
        eqf[i] = '0;
        prev[i] = '0;
      end
      run_sum = '0;
    endfunction

    function automatic logic [63:0] sat_one(input logic [63:0] v);
      return (v > 64'd32768) ? 64'd32768 : v;
    endfunction

    function automatic longint ln_fixed(input logic [63:0] s);
      int          p;
      logic [63:0] m, frac, mag;
      longint      l2;
      p = 0;
      frac = 0;
      for (int i = 0; i <= 15; i++) if (s[i]) p = i;
      m = s << (31 - p);
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 64'h1_0000_0000) begin
          m = m >> 1;
          frac[0] = 1'b1;
        end
      end
      l2 = (longint'(p) - 15) * 65536 + longint'(frac);
      mag = (64'(-l2) * 64'd2977044472) >> 32;
      return -longint'(mag);
    endfunction

    function void note_request(input logic [1:0] op, input logic [87:0] d);
      logic [63:0] tmp [4];
      logic [63:0] acc, pred, e, scale;
      longint      lg, s;
      site_out_t   r;
      logic        use_eq;
      if (op == hsf_pkg::OP_LOAD_TRANS) begin
        trans[d[1:0]][d[3:2]] = 16'(sat_one(64'(d[19:4])));
        return;
      end
      if (op == hsf_pkg::OP_LOAD_EQ) begin
        eqf[d[1:0]] = 16'(sat_one(64'(d[19:4])));
        return;
      end
      if (op != hsf_pkg::OP_SITE) return;
      use_eq = d[84] | d[85];
      scale = 0;
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++)
          acc += 64'(trans[k][j]) * 64'(use_eq ? eqf[k] : prev[k]);
        pred = sat_one(acc >> 15);
        e = sat_one(64'(d[20 + 16*j +: 16]));
        tmp[j] = (e * pred) >> 15;
        scale += tmp[j];
      end
      scale = sat_one(scale);
      if (d[84]) run_sum = '0;
      if (scale == 0) begin
        foreach (r.lik[j]) r.lik[j] = '0;
        lg = -64'sd8388608;
      end else begin
        foreach (r.lik[j]) r.lik[j] = 16'(sat_one((tmp[j] << 15) / scale));
        lg = ln_fixed(scale);
        if (lg < -64'sd8388608) lg = -64'sd8388608;
      end
      foreach (prev[j]) prev[j] = r.lik[j];
      s = longint'(run_sum) + lg;
      if (s < -longint'(64'sd140737488355328)) s = -64'sd140737488355328;
      run_sum = 48'(s);
      r.scale = 16'(scale);
      r.lg = 24'(lg);
      r.sum = run_sum;
      r.zero = (scale == 0);
      sites_seen++;
      if (r.zero) zero_seen++;
      pending.push_back(r);
    endfunction

    task check_result(input logic [151:0] d, input logic z);
      site_out_t w;
      if (pending.size() == 0) begin
        report("unexpected result", d[63:0], 0);
        return;
      end
      w = pending.pop_front();
      checked++;
      for (int j = 0; j < 4; j++)
        if (d[16*j +: 16] !== w.lik[j]) report($sformatf("lik_%0d", j), d[16*j +: 16], w.lik[j]);
      if (d[79:64] !== w.scale) report("site_scale", d[79:64], w.scale);
      if (d[103:80] !== w.lg) report("log_scale", d[103:80], 24'(w.lg));
      if (d[151:104] !== w.sum) report("running_log_lik", d[151:104], 48'(w.sum));
      if (z !== w.zero) report("zero_scale", z, w.zero);
    endtask
  endclass

  logic         clk_i = 0, rst_ni = 0;
  logic         s_axis_tvalid = 0, s_axis_tready;
  logic [87:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid, m_axis_tready = 0;
  logic [151:0] m_axis_tdata;
  logic         m_axis_tuser;

  forward_scoreboard sb = new();
  int  send_idle_pct = 0, recv_idle_pct = 0;
  int  hold_cycles = 0;

  hmm_scaled_forward_top DUT (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Receiver: random stalls, plus an explicit long hold-off.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Leave tvalid high on return so back-to-back requests need no gap.
  task automatic send(input logic [1:0] op, input logic [87:0] d);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_prob();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom);
      3: return 16'($urandom_range(255));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic logic [87:0] load_word(input int fr, input int to, input logic [15:0] v);
    logic [87:0] d;
    d = 88'({$urandom, $urandom, $urandom}) & 88'h3F_FFFF_FFFF_FFFF_FFFF_FFF0;
    d[1:0] = 2'(fr);
    d[3:2] = 2'(to);
    d[19:4] = v;
    return d;
  endfunction

  function automatic logic [87:0] site_word(input logic st, input logic rs);
    logic [87:0] d;
    d = '0;
    d[1:0] = 2'($urandom);
    d[3:2] = 2'($urandom);
    d[19:4] = 16'($urandom);
    for (int j = 0; j < 4; j++) d[20 + 16*j +: 16] = rand_prob();
    d[84] = st;
    d[85] = rs;
    return d;
  endfunction

  task automatic load_model(input bit extreme);
    for (int i = 0; i < 4; i++) begin
      send(hsf_pkg::OP_LOAD_EQ, load_word(i, 0, extreme ? 16'hFFFF : rand_prob()));
      for (int j = 0; j < 4; j++)
        send(hsf_pkg::OP_LOAD_TRANS, load_word(i, j, extreme ? 16'd32768 : rand_prob()));
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic random_phase(input int n);
    int len;
    while (n > 0) begin
      if ($urandom_range(19) == 0) load_model(0);
      if ($urandom_range(9) == 0) begin
        send($urandom_range(1) ? OP_UNUSED : hsf_pkg::OP_LOAD_TRANS,
             load_word($urandom, $urandom, rand_prob()));
      end
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        send(hsf_pkg::OP_SITE,
             site_word(i == 0 ? 1'($urandom_range(3) != 0) : 1'($urandom_range(15) == 0),
                       1'($urandom_range(9) == 0)));
        n--;
      end
    end
  endtask

  initial begin
    logic [87:0] d;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: site before any start, unused opcode, extremes, start plus restart.
    send(hsf_pkg::OP_SITE, site_word(0, 0));
    send(OP_UNUSED, load_word(1, 1, 16'd100));
    load_model(1);
    d = site_word(1, 0);
    for (int j = 0; j < 4; j++) d[20 + 16*j +: 16] = 16'hFFFF;
    send(hsf_pkg::OP_SITE, d);
    send(hsf_pkg::OP_SITE, site_word(0, 0));
    send(hsf_pkg::OP_SITE, site_word(1, 1));
    send(hsf_pkg::OP_SITE, site_word(0, 1));
    d = site_word(0, 0);
    d[83:20] = '0;
    send(hsf_pkg::OP_SITE, d);
    repeat (3) send(hsf_pkg::OP_SITE, site_word(0, 0));
    send(hsf_pkg::OP_SITE, {2'b00, 2'b11, 84'h0});
    drain();

    // Long receiver hold-off while the sender keeps offering sites.
    hold_cycles = 400;
    load_model(0);
    for (int i = 0; i < 6; i++) send(hsf_pkg::OP_SITE, site_word(i == 0, 0));
    drain();

    send_idle_pct = 31; recv_idle_pct = 86;
    random_phase(250);
    drain();
    send_idle_pct = 86; recv_idle_pct = 31;
    random_phase(250);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(250);
    drain();

    $display("covered %0d site results (%0d with zero scale), loads of both tables, unused opcodes",
             sb.checked, sb.zero_seen);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("hmm_scaled_forward_top test passed");
    end else begin
      $display("hmm_scaled_forward_top test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("hmm_scaled_forward_top test failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/hsf_pkg.sv
rtl/hsf_lane.sv
rtl/hsf_log.sv
rtl/hmm_scaled_forward_top.sv
tb/testbench.sv
